[src/nco_complex_mixer_macros.svh]
// Assertion macros shared by the NCO mixer RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef NCO_COMPLEX_MIXER_MACROS_SVH
`define NCO_COMPLEX_MIXER_MACROS_SVH

// Property checked on every rising clock edge, ignored while reset is held.
`define NCO_MIX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Property checked on every rising clock edge, reset included.
`define NCO_MIX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[src/nco_mix_pkg.sv]
// Types and constants for the NCO complex mixer.
// No dependencies; used by every module.
package nco_mix_pkg;

  // Number of CORDIC rotation stages.
  localparam int unsigned CORDIC_STAGES = 15;

  // Internal width of the CORDIC x, y and z datapath.
  localparam int unsigned CORDIC_W = 18;

  // Start value of x: full scale divided by the CORDIC gain.
  localparam logic signed [CORDIC_W-1:0] CORDIC_X_START = 18'sd19898;

  // Angles beyond plus or minus a quarter turn are folded by half a turn.
  localparam logic signed [15:0] FOLD_POS = 16'sd16384;
  localparam logic signed [15:0] FOLD_NEG = -16'sd16384;
  localparam logic signed [CORDIC_W-1:0] HALF_TURN = 18'sd32768;

  // Input sample beat.
  typedef struct packed {
    logic signed [15:0] in_real;
    logic signed [15:0] in_imag;
    logic               phase_restart;
  } sample_in_t;

  // Output sample beat.
  typedef struct packed {
    logic signed [15:0] out_real;
    logic signed [15:0] out_imag;
  } sample_out_t;

  // Configuration beat.
  typedef struct packed {
    logic signed [31:0] phase_step;
  } cfg_t;

  // Queue entry: the sample and the angle it is rotated by.
  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic signed [15:0] angle;
  } queue_t;

  // Arctangent of 2^-i in half turns (units of pi) scaled by 32768.
  function automatic int atan_lut(input int idx);
    int val;
    case (idx)
      0:  val = 8192;
      1:  val = 4836;
      2:  val = 2555;
      3:  val = 1297;
      4:  val = 651;
      5:  val = 326;
      6:  val = 163;
      7:  val = 81;
      8:  val = 41;
      9:  val = 20;
      10: val = 10;
      11: val = 5;
      12: val = 3;
      13: val = 1;
      14: val = 1;
      default: val = 0;
    endcase
    return val;
  endfunction

endpackage

[src/nco_mix_stream_if.sv]
// Valid/ready channel carrying one payload beat per handshake.
// The payload type is set where the channel is instantiated.
interface nco_mix_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/nco_complex_mixer.sv]
// Top level of the NCO complex mixer: front end, queue and rotation pipeline.
// Uses nco_mix_pkg, nco_mix_stream_if, nco_mix_front, nco_mix_fifo, nco_mix_back.
//
// Usage:
//   in_i carries one complex Q1.15 sample per beat plus a phase restart flag.
//   out_o returns one rotated, saturated sample per input beat, in order.
//   cfg_i writes the signed phase step; write it only while the block is idle.
//   Each sample is rotated by the top 16 bits of a 32-bit phase accumulator,
//   which then advances by the step. A restart clears the phase first.
// Timing:
//   One beat is accepted every clock cycle while out_o is not stalled. A sample
//   written into the queue passes one fold stage, 15 CORDIC stages, clamp,
//   multiply and output registers before it appears on out_o.
// Reset:
//   Clears the phase accumulator, the phase step and all valid flags.
// Stall:
//   While out_o is stalled the pipeline freezes; the queue then fills and
//   in_i.ready drops once it holds QueueDepth samples.
module nco_complex_mixer #(
  parameter int unsigned QueueDepth = 2
) (
  input logic              clk_i,
  input logic              rst_ni,
  nco_mix_stream_if.sink   in_i,
  nco_mix_stream_if.sink   cfg_i,
  nco_mix_stream_if.source out_o
);
  import nco_mix_pkg::*;

  nco_mix_stream_if #(.payload_t(queue_t)) q_front ();
  nco_mix_stream_if #(.payload_t(queue_t)) q_back ();

  nco_mix_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .q_o    (q_front)
  );

  nco_mix_fifo #(
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .snk_i  (q_front),
    .src_o  (q_back)
  );

  nco_mix_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .q_i    (q_back),
    .out_o  (out_o)
  );

endmodule

[src/nco_mix_front.sv]
// Front end of the NCO mixer: phase accumulator, step register, restart.
// Uses nco_mix_pkg and nco_mix_stream_if; feeds the sample queue.
module nco_mix_front (
  input logic              clk_i,
  input logic              rst_ni,
  nco_mix_stream_if.sink   in_i,
  nco_mix_stream_if.sink   cfg_i,
  nco_mix_stream_if.source q_o
);
  import nco_mix_pkg::*;

  logic [31:0] acc_q, acc_d;
  logic [31:0] step_q;
  logic [31:0] phase_use;
  logic        in_beat;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  // A sample passes straight into the queue when there is room.
  assign in_beat    = in_i.valid && q_o.ready;
  assign in_i.ready = q_o.ready;
  assign q_o.valid  = in_i.valid;

  // A restart rotates this sample by phase zero.
  assign phase_use = in_i.payload.phase_restart ? '0 : acc_q;

  always_comb begin
    q_o.payload.re    = in_i.payload.in_real;
    q_o.payload.im    = in_i.payload.in_imag;
    q_o.payload.angle = phase_use[31:16];
  end

  // The step is added after each sample, wrapping modulo 2^32.
  assign acc_d = in_beat ? (phase_use + step_q) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      step_q <= '0;
    end else begin
      acc_q <= acc_d;
      if (cfg_i.valid) begin
        step_q <= cfg_i.payload.phase_step;
      end
    end
  end

endmodule

[src/nco_mix_fifo.sv]
// Short queue between the front end and the rotation pipeline.
// Uses nco_mix_pkg, nco_mix_stream_if and the assertion macros.
`include "nco_complex_mixer_macros.svh"

module nco_mix_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input logic              clk_i,
  input logic              rst_ni,
  nco_mix_stream_if.sink   snk_i,
  nco_mix_stream_if.source src_o
);
  import nco_mix_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  queue_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  // Handshakes on both sides.
  assign snk_i.ready   = (cnt_q != CntW'(DEPTH));
  assign src_o.valid   = (cnt_q != '0);
  assign src_o.payload = mem_q[rd_ptr_q];
  assign push          = snk_i.valid && snk_i.ready;
  assign pop           = src_o.valid && src_o.ready;

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= snk_i.payload;
    end
  end

  `NCO_MIX_ASSERT(a_fifo_cnt_max, cnt_q <= CntW'(DEPTH), "queue overfilled")
  `NCO_MIX_ASSERT(a_fifo_cnt_up, (push && !pop) |=> (cnt_q == $past(cnt_q) + CntW'(1)), "count lost a push")

endmodule

[src/nco_mix_back.sv]
// Rotation pipeline: 15-stage CORDIC, complex multiply and saturation.
// Uses nco_mix_pkg, nco_mix_stream_if and the assertion macros.
`include "nco_complex_mixer_macros.svh"

module nco_mix_back (
  input logic              clk_i,
  input logic              rst_ni,
  nco_mix_stream_if.sink   q_i,
  nco_mix_stream_if.source out_o
);
  import nco_mix_pkg::*;

  // Fold stage plus one stage per rotation.
  localparam int unsigned NumStg = CORDIC_STAGES + 1;

  // Clamp an 18-bit value to plus or minus 32767.
  function automatic logic signed [15:0] sat_q15(input logic signed [CORDIC_W-1:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sd32767;
    end else if (v < -18'sd32767) begin
      r = -16'sd32767;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  logic                       en;
  logic [NumStg-1:0]          vld_q;
  logic [NumStg-1:0]          flip_q;
  logic signed [15:0]         re_q [NumStg];
  logic signed [15:0]         im_q [NumStg];
  logic signed [CORDIC_W-1:0] x_q  [NumStg];
  logic signed [CORDIC_W-1:0] y_q  [NumStg];
  logic signed [CORDIC_W-1:0] z_q  [NumStg];

  logic signed [15:0]         ang;
  logic signed [CORDIC_W-1:0] z_fold;
  logic                       flip_fold;

  logic                       vld_c_q;
  logic signed [15:0]         re_c_q, im_c_q, cos_q, sin_q;
  logic signed [15:0]         cos_sat, sin_sat;

  logic                       vld_m_q;
  logic signed [31:0]         p_rc_q, p_is_q, p_rs_q, p_ic_q;

  logic signed [32:0]         sum_r, sum_i;
  logic signed [32:0]         sh_r, sh_i;

  logic                       out_vld_q;
  sample_out_t                out_q;

  // The whole pipeline advances unless a finished beat is held.
  assign en          = !out_vld_q || out_o.ready;
  assign q_i.ready   = en;
  assign out_o.valid = out_vld_q;
  assign out_o.payload = out_q;

  // Fold the angle into a half turn around zero.
  always_comb begin
    ang       = q_i.payload.angle;
    z_fold    = CORDIC_W'(ang);
    flip_fold = 1'b0;
    if (ang > FOLD_POS) begin
      z_fold    = CORDIC_W'(ang) - HALF_TURN;
      flip_fold = 1'b1;
    end else if (ang < FOLD_NEG) begin
      z_fold    = CORDIC_W'(ang) + HALF_TURN;
      flip_fold = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_q[0]   <= q_i.payload.re;
      im_q[0]   <= q_i.payload.im;
      x_q[0]    <= CORDIC_X_START;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      flip_q[0] <= flip_fold;
    end
  end

  // One rotation per stage; shifts floor toward minus infinity.
  for (genvar k = 1; k < NumStg; k++) begin : g_rot
    logic signed [CORDIC_W-1:0] xs, ys, at;

    assign xs = x_q[k-1] >>> (k - 1);
    assign ys = y_q[k-1] >>> (k - 1);
    assign at = CORDIC_W'(atan_lut(k - 1));

    always_ff @(posedge clk_i) begin
      if (en) begin
        re_q[k]   <= re_q[k-1];
        im_q[k]   <= im_q[k-1];
        flip_q[k] <= flip_q[k-1];
        if (!z_q[k-1][CORDIC_W-1]) begin
          x_q[k] <= x_q[k-1] - ys;
          y_q[k] <= y_q[k-1] + xs;
          z_q[k] <= z_q[k-1] - at;
        end else begin
          x_q[k] <= x_q[k-1] + ys;
          y_q[k] <= y_q[k-1] - xs;
          z_q[k] <= z_q[k-1] + at;
        end
      end
    end
  end

  // Clamp cosine and sine, then undo the fold.
  assign cos_sat = sat_q15(x_q[NumStg-1]);
  assign sin_sat = sat_q15(y_q[NumStg-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      re_c_q <= re_q[NumStg-1];
      im_c_q <= im_q[NumStg-1];
      cos_q  <= flip_q[NumStg-1] ? -cos_sat : cos_sat;
      sin_q  <= flip_q[NumStg-1] ? -sin_sat : sin_sat;
    end
  end

  // Four partial products of the complex multiply.
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_rc_q <= 32'(re_c_q) * 32'(cos_q);
      p_is_q <= 32'(im_c_q) * 32'(sin_q);
      p_rs_q <= 32'(re_c_q) * 32'(sin_q);
      p_ic_q <= 32'(im_c_q) * 32'(cos_q);
    end
  end

  // Sum, floor shift by 15 and saturate.
  assign sum_r = 33'(p_rc_q) - 33'(p_is_q);
  assign sum_i = 33'(p_rs_q) + 33'(p_ic_q);
  assign sh_r  = sum_r >>> 15;
  assign sh_i  = sum_i >>> 15;

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.out_real <= sat_q15(sh_r[CORDIC_W-1:0]);
      out_q.out_imag <= sat_q15(sh_i[CORDIC_W-1:0]);
    end
  end

  // Beat tracking through every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      vld_c_q   <= 1'b0;
      vld_m_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NumStg-2:0], q_i.valid};
      vld_c_q   <= vld_q[NumStg-1];
      vld_m_q   <= vld_c_q;
      out_vld_q <= vld_m_q;
    end
  end

  `NCO_MIX_ASSERT(a_back_hold, (out_vld_q && !out_o.ready) |=> $stable(vld_q), "pipeline moved while stalled")
  `NCO_MIX_ASSERT(a_back_sat, out_vld_q |-> (out_q.out_real != 16'sh8000 && out_q.out_imag != 16'sh8000), "unsaturated output")

endmodule

[bench/tb_nco_complex_mixer.sv]
// Self-checking testbench for the NCO complex mixer: drives sample and step beats,
// predicts every rotated sample and checks the output stream in order.
// Depends on nco_mix_pkg, nco_mix_stream_if and the nco_complex_mixer RTL.
module tb_nco_complex_mixer;
  import nco_mix_pkg::*;

  // Rotation constants: Q1.15 full scale and the start value of the rotator.
  localparam longint Q15_MAX = 32767;
  localparam longint ROT_X_INIT = 19898;
  localparam int ROT_STAGES = 15;
  localparam int ARCTAN_STEP [ROT_STAGES] = '{
    8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
  };
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 30;
  localparam int ITEMS_PER_BLOCK = 82;
  localparam int HOLD_CYCLES = 150;

  // Expected rotated samples, built from a private copy of the oscillator state.
  class mixer_scoreboard;
    sample_out_t expected_rotations[$];
    logic [31:0] phase_acc;
    logic [31:0] phase_step;
    int          errors;
    int          checked;

    function new();
      phase_acc  = '0;
      phase_step = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function longint clamp_q15(longint v);
      if (v > Q15_MAX) begin
        return Q15_MAX;
      end
      if (v < -Q15_MAX) begin
        return -Q15_MAX;
      end
      return v;
    endfunction

    function int pending();
      return expected_rotations.size();
    endfunction

    function void set_step(logic [31:0] step);
      phase_step = step;
    endfunction

    // Rotate an accepted sample by the current phase, then advance the phase.
    function void note_sample(sample_in_t s);
      logic signed [15:0] angle;
      int                 z;
      int                 i;
      bit                 flip;
      longint             x, y, xs, ys, cos_v, sin_v, re, im, pr, pi_v;
      sample_out_t        exp_beat;
      if (s.phase_restart) begin
        phase_acc = '0;
      end
      angle = phase_acc[31:16];
      z = angle;
      flip = 1'b0;
      // Fold angles beyond a quarter turn by half a turn; the result flips sign.
      if (z > 16384) begin
        z -= 32768;
        flip = 1'b1;
      end else if (z < -16384) begin
        z += 32768;
        flip = 1'b1;
      end
      x = ROT_X_INIT;
      y = 0;
      for (i = 0; i < ROT_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= ARCTAN_STEP[i];
        end else begin
          x += ys;
          y -= xs;
          z += ARCTAN_STEP[i];
        end
      end
      cos_v = clamp_q15(x);
      sin_v = clamp_q15(y);
      if (flip) begin
        cos_v = -cos_v;
        sin_v = -sin_v;
      end
      // Complex product, floor shift by 15, saturate each part.
      re = longint'($signed(s.in_real));
      im = longint'($signed(s.in_imag));
      pr = re * cos_v - im * sin_v;
      pi_v = re * sin_v + im * cos_v;
      exp_beat.out_real = 16'(clamp_q15(pr >>> 15));
      exp_beat.out_imag = 16'(clamp_q15(pi_v >>> 15));
      expected_rotations.push_back(exp_beat);
      phase_acc = phase_acc + phase_step;
    endfunction

    // Compare an output beat with the oldest expected rotation.
    function void check_result(sample_out_t got);
      sample_out_t want;
      if (expected_rotations.size() == 0) begin
        $error("out beat with no sample pending: real %0d imag %0d",
               $signed(got.out_real), $signed(got.out_imag));
        errors++;
        return;
      end
      want = expected_rotations.pop_front();
      checked++;
      if (got.out_real !== want.out_real) begin
        $error("out_real: expected %0d, actual %0d",
               $signed(want.out_real), $signed(got.out_real));
        errors++;
      end
      if (got.out_imag !== want.out_imag) begin
        $error("out_imag: expected %0d, actual %0d",
               $signed(want.out_imag), $signed(got.out_imag));
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  nco_mix_stream_if #(.payload_t(sample_in_t))  in_ch ();
  nco_mix_stream_if #(.payload_t(cfg_t))        cfg_ch ();
  nco_mix_stream_if #(.payload_t(sample_out_t)) out_ch ();

  nco_complex_mixer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  mixer_scoreboard sb = new();

  int sender_gap_pct;
  int receiver_stall_pct;
  int hold_requests;
  int restarts_sent;
  int steps_written;
  int quiet_cycles;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus long hold-offs on request.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Monitor: every accepted beat on every channel goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        sb.set_step(cfg_ch.payload.phase_step);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_sample(in_ch.payload);
      end
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.payload);
      end
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d cycles without a beat", quiet_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one sample beat, with random gaps before it, until it is taken.
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, bit restart);
    sample_in_t beat;
    beat.in_real = re;
    beat.in_imag = im;
    beat.phase_restart = restart;
    while ($urandom_range(99) < sender_gap_pct) begin
      @(negedge clk_i);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_ch.valid   <= 1'b1;
    in_ch.payload <= beat;
    if (restart) begin
      restarts_sent++;
    end
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stop offering samples and wait for every expected rotation.
  task automatic drain_samples();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Write the phase step while the block is idle.
  task automatic write_phase_step(logic [31:0] step);
    cfg_t beat;
    drain_samples();
    beat.phase_step = step;
    @(negedge clk_i);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.payload <= beat;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    steps_written++;
  endtask

  // Sample field biased toward the extremes and the values around zero.
  function automatic logic signed [15:0] pick_field();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'shFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Phase step: extremes, tiny steps and fully random ones.
  function automatic logic [31:0] pick_step(int blk);
    case (blk)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(1, 1 << 20));
      3: return 32'hFFFF_FFFF;
      default: return 32'($urandom);
    endcase
  endfunction

  // Stimulus.
  initial begin
    int mode;
    int blk;
    int n;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.payload = '0;
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    hold_requests = 0;
    restarts_sent = 0;
    steps_written = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme samples at phase zero with the reset step.
    send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
    send_sample(16'sh8000, 16'sh8000, 1'b0);
    send_sample(16'sh8000, 16'sh7FFF, 1'b0);
    send_sample(16'sh7FFF, 16'sh8000, 1'b0);
    send_sample(16'sh0000, 16'sh0000, 1'b0);
    send_sample(16'sh0001, 16'shFFFF, 1'b1);

    // Directed: quarter-turn steps walk through both fold bounds and the half turn.
    write_phase_step(32'h4000_0000);
    send_sample(16'sh7FFF, 16'sh0000, 1'b1);
    for (n = 0; n < 6; n++) begin
      send_sample((n % 2) ? 16'sh8000 : 16'sh7FFF, (n % 3) ? 16'sh7FFF : 16'sh8000, 1'b0);
    end
    send_sample(16'sh4000, 16'shC000, 1'b1);

    // Directed: largest positive and negative steps, with wrap of the phase.
    write_phase_step(32'h7FFF_FFFF);
    for (n = 0; n < 4; n++) begin
      send_sample(16'sh7FFF, 16'sh7FFF, n == 0);
    end
    write_phase_step(32'h8000_0000);
    for (n = 0; n < 4; n++) begin
      send_sample(16'sh8000, 16'sh7FFF, 1'b0);
    end

    // Random: three idling profiles, several steps in each.
    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin sender_gap_pct = 28; receiver_stall_pct = 75; end
        1: begin sender_gap_pct = 75; receiver_stall_pct = 28; end
        default: begin sender_gap_pct = 0; receiver_stall_pct = 0; end
      endcase
      for (blk = 0; blk < 5; blk++) begin
        write_phase_step(pick_step((blk + mode) % 5));
        // Long receiver hold-off while samples keep coming, so the input stalls.
        if ((mode == 0 && blk == 2) || (mode == 2 && blk == 1)) begin
          hold_requests++;
        end
        for (n = 0; n < ITEMS_PER_BLOCK; n++) begin
          // A mid-block pause lets the pipeline empty with the phase carried on.
          if (n == ITEMS_PER_BLOCK / 2 && blk == 3) begin
            drain_samples();
          end
          send_sample(pick_field(), pick_field(), $urandom_range(15) == 0);
        end
      end
    end

    drain_samples();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Checked %0d rotated samples across %0d phase steps and %0d restarts,",
             sb.checked, steps_written, restarts_sent);
    $display("under sender gaps, receiver stalls, a full-pipeline hold and free flow.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[nco_complex_mixer.f]
+incdir+src
src/nco_mix_pkg.sv
src/nco_mix_stream_if.sv
src/nco_mix_front.sv
src/nco_mix_fifo.sv
src/nco_mix_back.sv
src/nco_complex_mixer.sv
bench/tb_nco_complex_mixer.sv
